// ----- hw/rtl/bcpeg_pkg.sv -----
// ----------------------------------------------------------------------------
// bcpeg_pkg
// Shared widths, codes and payload types of the bivariate cubic polynomial
// evaluator with gradient.
// ----------------------------------------------------------------------------
package bcpeg_pkg;

    // Field widths
    localparam int COEF_W = 32;     // coefficient, signed Q16.16
    localparam int PT_W   = 16;     // point coordinate, signed Q4.12
    localparam int PT_FRAC = 12;    // fraction bits of a coordinate
    localparam int RES_W  = 48;     // result, signed Q32.16
    localparam int TIDX_W = 4;      // term index
    localparam int DEG_W  = 2;      // degree register

    // Monomials 1, x, y, x2, xy, y2, x3, x2y, xy2, y3
    localparam int NUM_MONO = 10;
    localparam int MAX_TERMS_DEF = 10;

    localparam logic [DEG_W-1:0] DEGREE_RST = 2'd3;

    // Register stages of the arithmetic pipeline, output register included
    localparam int NUM_STAGES = 7;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } action_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    // One evaluate request: the point and a snapshot of the live coefficients
    typedef struct packed {
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        coef_t [NUM_MONO-1:0]    coef;
    } eval_req_t;

    // One result item
    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic signed [RES_W-1:0] slope_x;
        logic signed [RES_W-1:0] slope_y;
        logic                    saturated;
    } result_t;

    // Number of monomials in use for a given total degree
    function automatic logic [TIDX_W-1:0] terms_for_degree(input logic [DEG_W-1:0] deg);
        logic [TIDX_W-1:0] n;
        case (deg)
            2'd0:    n = 4'd1;
            2'd1:    n = 4'd3;
            2'd2:    n = 4'd6;
            2'd3:    n = 4'd10;
            default: n = 4'd10;
        endcase
        return n;
    endfunction

endpackage

// ----- hw/rtl/bcpeg_pipe.sv -----
// ----------------------------------------------------------------------------
// bcpeg_pipe
// Seven-stage arithmetic pipeline: monomials, coefficient products, exact
// sums in Q.52, then rounding to Q32.16 and clipping to 48 bits.
// ----------------------------------------------------------------------------
module bcpeg_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  bcpeg_pkg::eval_req_t  req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output bcpeg_pkg::result_t    res
);
    import bcpeg_pkg::*;

    localparam int MONO_W     = 2 * PT_W;
    localparam int LIN_W      = COEF_W + PT_W;
    localparam int QUAD_W     = COEF_W + MONO_W;
    localparam int SPLIT      = LIN_W / 2;
    localparam int CUBH_W     = LIN_W - SPLIT + MONO_W;
    localparam int CUBL_W     = SPLIT + 1 + MONO_W;
    localparam int QUAD_SHIFT = PT_FRAC;
    localparam int LIN_SHIFT  = 2 * PT_FRAC;
    localparam int FRAC_SHIFT = 3 * PT_FRAC;
    localparam int SUM_W      = 88;
    localparam int R_W        = SUM_W - FRAC_SHIFT;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // High part of a linear product times a degree-two monomial
    function automatic logic signed [CUBH_W-1:0] mul_hi(
        input logic signed [LIN_W-1:0]  lin,
        input logic signed [MONO_W-1:0] mono
    );
        logic signed [LIN_W-SPLIT-1:0] h;
        h = $signed(lin[LIN_W-1:SPLIT]);
        return CUBH_W'(h) * CUBH_W'(mono);
    endfunction

    // Low part, taken as unsigned
    function automatic logic signed [CUBL_W-1:0] mul_lo(
        input logic signed [LIN_W-1:0]  lin,
        input logic signed [MONO_W-1:0] mono
    );
        logic signed [SPLIT:0] l;
        l = $signed({1'b0, lin[SPLIT-1:0]});
        return CUBL_W'(l) * CUBL_W'(mono);
    endfunction

    // Drop the fraction (round offset already added) and clip to 48 bits
    function automatic logic [RES_W:0] round_clip(input logic signed [SUM_W-1:0] s);
        logic [R_W-1:0] r;
        logic           ovf;
        logic [RES_W-1:0] v;
        r   = s[SUM_W-1:FRAC_SHIFT];
        ovf = !((&r[R_W-1:RES_W-1]) || !(|r[R_W-1:RES_W-1]));
        if (!ovf)
            v = r[RES_W-1:0];
        else if (r[R_W-1])
            v = RES_MIN;
        else
            v = RES_MAX;
        return {ovf, v};
    endfunction

    // ------------------------------------------------------------------
    // Valid bits and per-stage enables
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || res_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = req_valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (stage_en[i])
                    vld_reg[i] <= vld_next[i];
            end
        end
    end

    assign req_ready = stage_en[0];
    assign res_valid = vld_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: capture point and coefficient snapshot
    // ------------------------------------------------------------------
    logic signed [PT_W-1:0] s1_x_reg, s1_y_reg;
    coef_t                  s1_coef_reg [NUM_MONO];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_x_reg <= req.x;
            s1_y_reg <= req.y;
            for (int k = 0; k < NUM_MONO; k++)
            begin
                s1_coef_reg[k] <= req.coef[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: degree-two monomials and coefficient-by-coordinate products
    // ------------------------------------------------------------------
    logic signed [MONO_W-1:0] s2_xx_next, s2_xy_next, s2_yy_next;
    logic signed [MONO_W-1:0] s2_xx_reg, s2_xy_reg, s2_yy_reg;
    logic signed [LIN_W-1:0]  s2_p1x_next, s2_p2y_next, s2_g3x_next, s2_g4y_next;
    logic signed [LIN_W-1:0]  s2_h4x_next, s2_h5y_next;
    logic signed [LIN_W-1:0]  s2_q6_next, s2_q7_next, s2_q8_next, s2_q9_next;
    logic signed [LIN_W-1:0]  s2_p1x_reg, s2_p2y_reg, s2_g3x_reg, s2_g4y_reg;
    logic signed [LIN_W-1:0]  s2_h4x_reg, s2_h5y_reg;
    logic signed [LIN_W-1:0]  s2_q6_reg, s2_q7_reg, s2_q8_reg, s2_q9_reg;
    coef_t                    s2_coef_reg [NUM_MONO];

    always_comb
    begin
        s2_xx_next  = MONO_W'(s1_x_reg) * MONO_W'(s1_x_reg);
        s2_xy_next  = MONO_W'(s1_x_reg) * MONO_W'(s1_y_reg);
        s2_yy_next  = MONO_W'(s1_y_reg) * MONO_W'(s1_y_reg);
        s2_p1x_next = LIN_W'(s1_coef_reg[1]) * LIN_W'(s1_x_reg);
        s2_p2y_next = LIN_W'(s1_coef_reg[2]) * LIN_W'(s1_y_reg);
        s2_g3x_next = LIN_W'(s1_coef_reg[3]) * LIN_W'(s1_x_reg);
        s2_g4y_next = LIN_W'(s1_coef_reg[4]) * LIN_W'(s1_y_reg);
        s2_h4x_next = LIN_W'(s1_coef_reg[4]) * LIN_W'(s1_x_reg);
        s2_h5y_next = LIN_W'(s1_coef_reg[5]) * LIN_W'(s1_y_reg);
        s2_q6_next  = LIN_W'(s1_coef_reg[6]) * LIN_W'(s1_x_reg);
        s2_q7_next  = LIN_W'(s1_coef_reg[7]) * LIN_W'(s1_x_reg);
        s2_q8_next  = LIN_W'(s1_coef_reg[8]) * LIN_W'(s1_x_reg);
        s2_q9_next  = LIN_W'(s1_coef_reg[9]) * LIN_W'(s1_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_xx_reg  <= s2_xx_next;
            s2_xy_reg  <= s2_xy_next;
            s2_yy_reg  <= s2_yy_next;
            s2_p1x_reg <= s2_p1x_next;
            s2_p2y_reg <= s2_p2y_next;
            s2_g3x_reg <= s2_g3x_next;
            s2_g4y_reg <= s2_g4y_next;
            s2_h4x_reg <= s2_h4x_next;
            s2_h5y_reg <= s2_h5y_next;
            s2_q6_reg  <= s2_q6_next;
            s2_q7_reg  <= s2_q7_next;
            s2_q8_reg  <= s2_q8_next;
            s2_q9_reg  <= s2_q9_next;
            for (int k = 0; k < NUM_MONO; k++)
            begin
                s2_coef_reg[k] <= s1_coef_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: coefficient-by-monomial products, cubic terms in two halves
    // ------------------------------------------------------------------
    logic signed [QUAD_W-1:0] s3_v3_next, s3_v4_next, s3_v5_next;
    logic signed [QUAD_W-1:0] s3_gx6_next, s3_gx7_next, s3_gx8_next;
    logic signed [QUAD_W-1:0] s3_gy7_next, s3_gy8_next, s3_gy9_next;
    logic signed [QUAD_W-1:0] s3_v3_reg, s3_v4_reg, s3_v5_reg;
    logic signed [QUAD_W-1:0] s3_gx6_reg, s3_gx7_reg, s3_gx8_reg;
    logic signed [QUAD_W-1:0] s3_gy7_reg, s3_gy8_reg, s3_gy9_reg;
    logic signed [CUBH_W-1:0] s3_c6h_next, s3_c7h_next, s3_c8h_next, s3_c9h_next;
    logic signed [CUBH_W-1:0] s3_c6h_reg, s3_c7h_reg, s3_c8h_reg, s3_c9h_reg;
    logic signed [CUBL_W-1:0] s3_c6l_next, s3_c7l_next, s3_c8l_next, s3_c9l_next;
    logic signed [CUBL_W-1:0] s3_c6l_reg, s3_c7l_reg, s3_c8l_reg, s3_c9l_reg;
    logic signed [LIN_W-1:0]  s3_p1x_reg, s3_p2y_reg, s3_g3x_reg, s3_g4y_reg;
    logic signed [LIN_W-1:0]  s3_h4x_reg, s3_h5y_reg;
    coef_t                    s3_c0_reg, s3_c1_reg, s3_c2_reg;

    always_comb
    begin
        s3_v3_next  = QUAD_W'(s2_coef_reg[3]) * QUAD_W'(s2_xx_reg);
        s3_v4_next  = QUAD_W'(s2_coef_reg[4]) * QUAD_W'(s2_xy_reg);
        s3_v5_next  = QUAD_W'(s2_coef_reg[5]) * QUAD_W'(s2_yy_reg);
        s3_gx6_next = QUAD_W'(s2_coef_reg[6]) * QUAD_W'(s2_xx_reg);
        s3_gx7_next = QUAD_W'(s2_coef_reg[7]) * QUAD_W'(s2_xy_reg);
        s3_gx8_next = QUAD_W'(s2_coef_reg[8]) * QUAD_W'(s2_yy_reg);
        s3_gy7_next = QUAD_W'(s2_coef_reg[7]) * QUAD_W'(s2_xx_reg);
        s3_gy8_next = QUAD_W'(s2_coef_reg[8]) * QUAD_W'(s2_xy_reg);
        s3_gy9_next = QUAD_W'(s2_coef_reg[9]) * QUAD_W'(s2_yy_reg);
        s3_c6h_next = mul_hi(s2_q6_reg, s2_xx_reg);
        s3_c6l_next = mul_lo(s2_q6_reg, s2_xx_reg);
        s3_c7h_next = mul_hi(s2_q7_reg, s2_xy_reg);
        s3_c7l_next = mul_lo(s2_q7_reg, s2_xy_reg);
        s3_c8h_next = mul_hi(s2_q8_reg, s2_yy_reg);
        s3_c8l_next = mul_lo(s2_q8_reg, s2_yy_reg);
        s3_c9h_next = mul_hi(s2_q9_reg, s2_yy_reg);
        s3_c9l_next = mul_lo(s2_q9_reg, s2_yy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_v3_reg  <= s3_v3_next;
            s3_v4_reg  <= s3_v4_next;
            s3_v5_reg  <= s3_v5_next;
            s3_gx6_reg <= s3_gx6_next;
            s3_gx7_reg <= s3_gx7_next;
            s3_gx8_reg <= s3_gx8_next;
            s3_gy7_reg <= s3_gy7_next;
            s3_gy8_reg <= s3_gy8_next;
            s3_gy9_reg <= s3_gy9_next;
            s3_c6h_reg <= s3_c6h_next;
            s3_c6l_reg <= s3_c6l_next;
            s3_c7h_reg <= s3_c7h_next;
            s3_c7l_reg <= s3_c7l_next;
            s3_c8h_reg <= s3_c8h_next;
            s3_c8l_reg <= s3_c8l_next;
            s3_c9h_reg <= s3_c9h_next;
            s3_c9l_reg <= s3_c9l_next;
            s3_p1x_reg <= s2_p1x_reg;
            s3_p2y_reg <= s2_p2y_reg;
            s3_g3x_reg <= s2_g3x_reg;
            s3_g4y_reg <= s2_g4y_reg;
            s3_h4x_reg <= s2_h4x_reg;
            s3_h5y_reg <= s2_h5y_reg;
            s3_c0_reg  <= s2_coef_reg[0];
            s3_c1_reg  <= s2_coef_reg[1];
            s3_c2_reg  <= s2_coef_reg[2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rejoin cubic halves, weight and sum terms of equal degree
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] s4_u6_next, s4_u7_next, s4_u8_next, s4_u9_next;
    logic signed [SUM_W-1:0] s4_u6_reg, s4_u7_reg, s4_u8_reg, s4_u9_reg;
    logic signed [SUM_W-1:0] s4_vq_next, s4_gxq_next, s4_gyq_next;
    logic signed [SUM_W-1:0] s4_vq_reg, s4_gxq_reg, s4_gyq_reg;
    logic signed [SUM_W-1:0] s4_vl_next, s4_gxl_next, s4_gyl_next;
    logic signed [SUM_W-1:0] s4_vl_reg, s4_gxl_reg, s4_gyl_reg;
    coef_t                   s4_c0_reg, s4_c1_reg, s4_c2_reg;

    always_comb
    begin
        s4_u6_next  = (SUM_W'(s3_c6h_reg) <<< SPLIT) + SUM_W'(s3_c6l_reg);
        s4_u7_next  = (SUM_W'(s3_c7h_reg) <<< SPLIT) + SUM_W'(s3_c7l_reg);
        s4_u8_next  = (SUM_W'(s3_c8h_reg) <<< SPLIT) + SUM_W'(s3_c8l_reg);
        s4_u9_next  = (SUM_W'(s3_c9h_reg) <<< SPLIT) + SUM_W'(s3_c9l_reg);
        s4_vq_next  = SUM_W'(s3_v3_reg) + SUM_W'(s3_v4_reg) + SUM_W'(s3_v5_reg);
        // x3 term weighs 3, x2y term weighs 2 in d/dx
        s4_gxq_next = (SUM_W'(s3_gx6_reg) <<< 1) + SUM_W'(s3_gx6_reg)
                    + (SUM_W'(s3_gx7_reg) <<< 1) + SUM_W'(s3_gx8_reg);
        s4_gyq_next = SUM_W'(s3_gy7_reg) + (SUM_W'(s3_gy8_reg) <<< 1)
                    + (SUM_W'(s3_gy9_reg) <<< 1) + SUM_W'(s3_gy9_reg);
        s4_vl_next  = SUM_W'(s3_p1x_reg) + SUM_W'(s3_p2y_reg);
        s4_gxl_next = (SUM_W'(s3_g3x_reg) <<< 1) + SUM_W'(s3_g4y_reg);
        s4_gyl_next = SUM_W'(s3_h4x_reg) + (SUM_W'(s3_h5y_reg) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_u6_reg  <= s4_u6_next;
            s4_u7_reg  <= s4_u7_next;
            s4_u8_reg  <= s4_u8_next;
            s4_u9_reg  <= s4_u9_next;
            s4_vq_reg  <= s4_vq_next;
            s4_gxq_reg <= s4_gxq_next;
            s4_gyq_reg <= s4_gyq_next;
            s4_vl_reg  <= s4_vl_next;
            s4_gxl_reg <= s4_gxl_next;
            s4_gyl_reg <= s4_gyl_next;
            s4_c0_reg  <= s3_c0_reg;
            s4_c1_reg  <= s3_c1_reg;
            s4_c2_reg  <= s3_c2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: align to Q.52, add round offset, pair up cubic terms
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] s5_vc01_next, s5_vc23_next, s5_vlow_next;
    logic signed [SUM_W-1:0] s5_gx_next, s5_gy_next;
    logic signed [SUM_W-1:0] s5_vc01_reg, s5_vc23_reg, s5_vlow_reg;
    logic signed [SUM_W-1:0] s5_gx_reg, s5_gy_reg;

    always_comb
    begin
        s5_vc01_next = s4_u6_reg + s4_u7_reg;
        s5_vc23_next = s4_u8_reg + s4_u9_reg;
        s5_vlow_next = ((SUM_W'(s4_c0_reg) <<< FRAC_SHIFT) | $signed(ROUND_HALF))
                     + (s4_vl_reg <<< LIN_SHIFT) + (s4_vq_reg <<< QUAD_SHIFT);
        s5_gx_next   = ((SUM_W'(s4_c1_reg) <<< FRAC_SHIFT) | $signed(ROUND_HALF))
                     + (s4_gxl_reg <<< LIN_SHIFT) + (s4_gxq_reg <<< QUAD_SHIFT);
        s5_gy_next   = ((SUM_W'(s4_c2_reg) <<< FRAC_SHIFT) | $signed(ROUND_HALF))
                     + (s4_gyl_reg <<< LIN_SHIFT) + (s4_gyq_reg <<< QUAD_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_vc01_reg <= s5_vc01_next;
            s5_vc23_reg <= s5_vc23_next;
            s5_vlow_reg <= s5_vlow_next;
            s5_gx_reg   <= s5_gx_next;
            s5_gy_reg   <= s5_gy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: complete the value sum
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] s6_val_next;
    logic signed [SUM_W-1:0] s6_val_reg, s6_gx_reg, s6_gy_reg;

    assign s6_val_next = s5_vlow_reg + s5_vc01_reg + s5_vc23_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s6_val_reg <= s6_val_next;
            s6_gx_reg  <= s5_gx_reg;
            s6_gy_reg  <= s5_gy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: round, clip, flag
    // ------------------------------------------------------------------
    logic [RES_W:0] rc_val, rc_gx, rc_gy;
    result_t        res_next;
    result_t        res_reg;

    always_comb
    begin
        rc_val = round_clip(s6_val_reg);
        rc_gx  = round_clip(s6_gx_reg);
        rc_gy  = round_clip(s6_gy_reg);
        res_next.value     = rc_val[RES_W-1:0];
        res_next.slope_x   = rc_gx[RES_W-1:0];
        res_next.slope_y   = rc_gy[RES_W-1:0];
        res_next.saturated = rc_val[RES_W] | rc_gx[RES_W] | rc_gy[RES_W];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[NUM_STAGES-1])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/bivariate_cubic_poly_eval_gradient_top.sv -----
// ----------------------------------------------------------------------------
// bivariate_cubic_poly_eval_gradient_top
// Throughput: one item per cycle, loads and evaluates alike, while out_ready
// keeps the pipeline moving; the seven register stages hold the captured
// request, the multiplier levels, the wide sums and the rounded result.
// Reset: coefficients clear to zero, degree returns to 3, pipeline empties.
// Loads write the coefficient store in the cycle of their transfer.
// ----------------------------------------------------------------------------
module bivariate_cubic_poly_eval_gradient_top #(
    parameter int MAX_TERMS = bcpeg_pkg::MAX_TERMS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [bcpeg_pkg::DEG_W-1:0]           cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic [bcpeg_pkg::TIDX_W-1:0]          term_index,
    input  logic signed [bcpeg_pkg::COEF_W-1:0]   term_value,
    input  logic signed [bcpeg_pkg::PT_W-1:0]     point_x,
    input  logic signed [bcpeg_pkg::PT_W-1:0]     point_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bcpeg_pkg::RES_W-1:0]    poly_value,
    output logic signed [bcpeg_pkg::RES_W-1:0]    slope_x,
    output logic signed [bcpeg_pkg::RES_W-1:0]    slope_y,
    output logic                                  saturated
);
    import bcpeg_pkg::*;

    logic [DEG_W-1:0]  degree_reg;
    coef_t             coef_reg [MAX_TERMS];
    logic              load_xfer;
    logic              eval_valid;
    logic              eval_ready;
    logic [TIDX_W-1:0] n_used;
    coef_t [NUM_MONO-1:0] coef_live;
    eval_req_t         req;
    result_t           res;

    // Degree register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degree_reg <= DEGREE_RST;
        else if (cfg_wr_en)
            degree_reg <= cfg_wr_data;
    end

    // Coefficient store; loads beyond the store match no entry and drop
    assign load_xfer = in_valid && in_ready && (action == ACT_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TERMS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < MAX_TERMS; k++)
            begin
                if (load_xfer && (term_index == TIDX_W'(k)))
                    coef_reg[k] <= term_value;
            end
        end
    end

    // Snapshot the coefficients in use; terms above the degree read as zero
    assign n_used = terms_for_degree(degree_reg);

    for (genvar k = 0; k < NUM_MONO; k++)
    begin : g_snap
        if (k < MAX_TERMS)
        begin : g_live
            assign coef_live[k] = (TIDX_W'(k) < n_used) ? coef_reg[k] : '0;
        end
        else
        begin : g_none
            assign coef_live[k] = '0;
        end
    end

    // Evaluate requests go down the pipeline
    assign eval_valid = in_valid && (action == ACT_EVAL);
    assign req.x      = point_x;
    assign req.y      = point_y;
    assign req.coef   = coef_live;
    assign in_ready   = eval_ready;

    bcpeg_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (eval_valid),
        .req_ready (eval_ready),
        .req       (req),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign poly_value = res.value;
    assign slope_x    = res.slope_x;
    assign slope_y    = res.slope_y;
    assign saturated  = res.saturated;

    // Results always fit 48 bits with these field widths
    a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !saturated)
        else $error("result clipped");

    // A load to slot 0 lands in the store on the next edge
    a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (load_xfer && (term_index == '0)) |=> (coef_reg[0] == $past(term_value)))
        else $error("coefficient load lost");

    // A draining output never blocks the input
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule
